// ===== rtl/rlel_pkg.sv =====
`default_nettype none
package rlel_pkg;

  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_NEWDAY = 2'd2;

  localparam int LIMIT_W     = 10;
  localparam int EVT_W       = 16;
  localparam int BCD_W       = 48;
  localparam int ENTRY_W     = 2 * EVT_W + BCD_W;
  localparam int CALC_W      = 17;
  localparam int IN_TDATA_W  = 96;
  localparam int OUT_TDATA_W = 88;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 10'd512;

  // reciprocal of 100 scaled by 2^19, good for any 14-bit year
  localparam logic [12:0] RECIP_100 = 13'd5243;
  localparam int          RECIP_SH  = 19;

  typedef logic [BCD_W-1:0] stamp_t;

  // first member sits in the highest bits
  typedef struct packed {
    logic [15:0]      back_count;
    logic [EVT_W-1:0] evt_sub;
    logic [EVT_W-1:0] evt_type;
  } evt_fields_t;

  // two-digit BCD of a value below 100
  function automatic logic [7:0] bcd2(input logic [6:0] v);
    logic [3:0] tens;
    logic [6:0] ones;
    tens = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (v >= 7'(10 * k)) tens = 4'(k);
    end
    ones = v - 7'(tens) * 7'd10;
    return {tens, ones[3:0]};
  endfunction

endpackage
`default_nettype wire

// ===== rtl/rlel_stamp.sv =====
`default_nettype none
module rlel_stamp import rlel_pkg::*; (
  input  wire logic        clk,
  input  wire logic        load,
  input  wire logic [5:0]  time_second,
  input  wire logic [5:0]  time_minute,
  input  wire logic [4:0]  time_hour,
  input  wire logic [4:0]  time_day,
  input  wire logic [3:0]  time_month,
  input  wire logic [13:0] time_year,
  output stamp_t           stamp
);

  logic [5:0]  sec_r, min_r;
  logic [4:0]  hour_r, day_r;
  logic [3:0]  month_r;
  logic [13:0] year_r;
  logic [7:0]  yq_r;
  logic [26:0] yprod;
  logic [13:0] yrem;

  // quotient year/100 is registered; the remainder is finished next cycle
  assign yprod = 27'(time_year) * 27'(RECIP_100);

  always_ff @(posedge clk) begin
    if (load) begin
      sec_r   <= time_second;
      min_r   <= time_minute;
      hour_r  <= time_hour;
      day_r   <= time_day;
      month_r <= time_month;
      year_r  <= time_year;
      yq_r    <= yprod[RECIP_SH +: 8];
    end
  end

  assign yrem = year_r - 14'(yq_r) * 14'd100;

  assign stamp = {bcd2(yrem[6:0]),
                  bcd2({3'd0, month_r}),
                  bcd2({2'd0, day_r}),
                  bcd2({2'd0, hour_r}),
                  bcd2({1'b0, min_r}),
                  bcd2({1'b0, sec_r})};

endmodule
`default_nettype wire

// ===== rtl/rlel_mem.sv =====
`default_nettype none
module rlel_mem import rlel_pkg::*; #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  wire logic               clk,
  input  wire logic               we,
  input  wire logic [AW-1:0]      waddr,
  input  wire logic [ENTRY_W-1:0] wdata,
  input  wire logic               re,
  input  wire logic [AW-1:0]      raddr,
  output logic      [ENTRY_W-1:0] rdata
);

  logic [ENTRY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/rate_limited_event_ring_log_top.sv =====
// The result enters the output register as the execute state ends.
// No new item until the last is through; the log memory is read in the accept cycle
// and written, with the result formed, in the execute state (one port each way).
// A result waiting at the output holds the block in its execute state.
// Reset: control, write position and quota clear, limit returns to 512; the log
// reads as zero through a fill mark (no clearing pass).
`default_nettype none
module rate_limited_event_ring_log_top import rlel_pkg::*; #(
  parameter int LOG_DEPTH = 256
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // opcode, event_type, event_sub, back_count, time_second, time_minute,
  // time_hour, time_day, time_month, time_year, zero fill
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // accepted, read_event_type, read_event_sub, read_time_bcd, zero fill
  output logic      [OUT_TDATA_W-1:0] out_tdata,
  input  wire logic                   cfg_wr_en,
  input  wire logic [LIMIT_W-1:0]     cfg_wr_data
);

  localparam int AW = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
  localparam int PW = $clog2(LOG_DEPTH + 1);
  localparam logic [CALC_W-1:0] DEPTH_C = CALC_W'(LOG_DEPTH);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic               state_r, state_nxt;
  logic [1:0]         op_r;
  evt_fields_t        fld_r;
  logic               rd_ok_r, rd_hit_r;
  logic [PW-1:0]      wpos_r, wpos_nxt;
  logic               full_r, full_nxt;
  logic [LIMIT_W-1:0] cnt_r, cnt_nxt;
  logic [LIMIT_W-1:0] limit_r;
  logic               out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic               accept, exec_done;
  evt_fields_t        in_fld;
  logic [CALC_W-1:0]  num, pos, rp;
  logic               num_ok, hit;

  stamp_t             stamp;
  logic [ENTRY_W-1:0] rdata;
  logic               mem_we;
  logic [PW-1:0]      wr_pos;
  logic               acc;
  logic [ENTRY_W-1:0] rd_entry;

  assign in_fld    = evt_fields_t'(in_tdata[49:2]);
  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign exec_done = (state_r == ST_EXEC) && (!out_valid_r || out_tready);

  // read address: back_count entries behind the write position, modulo depth
  assign num    = CALC_W'(in_fld.back_count);
  assign pos    = CALC_W'(wpos_r);
  assign num_ok = (num != '0) && (num <= DEPTH_C);
  assign rp     = (pos >= num) ? (pos - num) : (pos + DEPTH_C - num);
  assign hit    = full_r || (rp < pos);

  rlel_stamp u_stamp (
    .clk         (clk),
    .load        (accept),
    .time_second (in_tdata[55:50]),
    .time_minute (in_tdata[61:56]),
    .time_hour   (in_tdata[66:62]),
    .time_day    (in_tdata[71:67]),
    .time_month  (in_tdata[75:72]),
    .time_year   (in_tdata[89:76]),
    .stamp       (stamp)
  );

  rlel_mem #(
    .DEPTH (LOG_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (wr_pos[AW-1:0]),
    .wdata ({stamp, fld_r.evt_sub, fld_r.evt_type}),
    .re    (accept),
    .raddr (rp[AW-1:0]),
    .rdata (rdata)
  );

  assign wr_pos = (wpos_r >= PW'(LOG_DEPTH)) ? '0 : wpos_r;

  always_comb begin
    state_nxt = state_r;
    wpos_nxt  = wpos_r;
    full_nxt  = full_r;
    cnt_nxt   = cnt_r;
    mem_we    = 1'b0;
    acc       = 1'b0;
    rd_entry  = '0;
    if (accept) state_nxt = ST_EXEC;
    if (exec_done) begin
      state_nxt = ST_IDLE;
      unique case (op_r)
        OP_WRITE: begin
          if (cnt_r < limit_r) begin
            mem_we   = 1'b1;
            acc      = 1'b1;
            cnt_nxt  = cnt_r + 1'b1;
            wpos_nxt = wr_pos + 1'b1;
            if (wr_pos == PW'(LOG_DEPTH - 1)) full_nxt = 1'b1;
          end
        end
        OP_READ: begin
          acc = rd_ok_r;
          if (rd_ok_r && rd_hit_r) rd_entry = rdata;
        end
        OP_NEWDAY: begin
          acc     = 1'b1;
          cnt_nxt = '0;
        end
        default: ;
      endcase
    end
    out_data_nxt = OUT_TDATA_W'({rd_entry, acc});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wpos_r      <= '0;
      full_r      <= 1'b0;
      cnt_r       <= '0;
      limit_r     <= LIMIT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wpos_r  <= wpos_nxt;
      full_r  <= full_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_wr_en) limit_r <= cfg_wr_data;
      if (exec_done) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= in_tdata[1:0];
      fld_r    <= in_fld;
      rd_ok_r  <= num_ok;
      rd_hit_r <= hit;
    end
    if (exec_done) out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_accept_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_EXEC) && !in_tready)
    else $error("accept did not move to exec");

  a_wpos_range: assert property (@(posedge clk) disable iff (!rst_n)
    wpos_r <= PW'(LOG_DEPTH))
    else $error("write position beyond depth");

  a_quota: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> cnt_r < limit_r)
    else $error("write stored past daily quota");

  a_out_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_EXEC)
    else $error("result appeared without exec cycle");

  a_pos_moves_on_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |=> wpos_r == $past(wpos_r))
    else $error("write position changed with no item at work");

endmodule
`default_nettype wire
